// ===== rtl/mlpsig_pkg.sv =====
// ----------------------------------------------------------------------------
// mlpsig_pkg
// Shared sizes, address map, control struct and sigmoid table of the
// two-layer perceptron inference core.
// ----------------------------------------------------------------------------
package mlpsig_pkg;

  localparam int MAX_INPUTS  = 16;
  localparam int MAX_HIDDEN  = 32;
  localparam int SIG_DEPTH   = 256;
  localparam int FEAT_AW     = $clog2(MAX_INPUTS);
  localparam int CELL_AW     = $clog2(MAX_HIDDEN);
  localparam int SIG_AW      = $clog2(SIG_DEPTH);
  localparam int CNT_W       = CELL_AW + 1;

  localparam int W1_DEPTH    = MAX_HIDDEN * MAX_INPUTS;
  localparam int B1_BASE     = W1_DEPTH;
  localparam int W2_BASE     = B1_BASE + MAX_HIDDEN;
  localparam int B2_ADDR     = W2_BASE + MAX_HIDDEN;

  localparam int HACC_W      = 40;
  localparam int PROD_W      = 33;
  localparam int OACC_W      = 40;

  localparam logic [1:0] REG_INPUT_COUNT  = 2'd0;
  localparam logic [1:0] REG_HIDDEN_COUNT = 2'd1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HID,
    ST_ACT,
    ST_OUT,
    ST_FIN
  } state_e;

  // Broadcast from the sequencer to every hidden cell.
  typedef struct packed {
    logic               wr_w1;
    logic               wr_b1;
    logic               wr_w2;
    logic [FEAT_AW-1:0] w_addr;
    logic signed [15:0] w_data;
    logic               load;
    logic               mac;
    logic signed [15:0] x;
    logic               act;
    logic               shift;
  } cell_ctrl_t;

  typedef logic [15:0] sig_table_t [SIG_DEPTH];

  // Unsigned quotient by restoring long division; used only while the
  // sigmoid table is built at elaboration.
  function automatic longint unsigned udiv64(input longint unsigned num,
                                             input longint unsigned den);
    longint unsigned rem;
    longint unsigned quo;
    rem = '0;
    quo = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[62:0], num[b]};
      quo = quo << 1;
      if (rem >= den) begin
        rem = rem - den;
        quo = quo | 64'd1;
      end
    end
    return quo;
  endfunction

  // e^-a, a in Q.30 between 0 and 8; result in Q.30.
  function automatic longint unsigned exp_neg_q30(input longint unsigned a);
    longint unsigned one_q30;
    longint unsigned u;
    longint unsigned u2;
    longint unsigned u3;
    longint unsigned u4;
    longint unsigned e;
    one_q30 = 64'd1 << 30;
    u  = a >> 8;
    u2 = (u * u) >> 30;
    u3 = (u2 * u) >> 30;
    u4 = (u3 * u) >> 30;
    e  = one_q30 - u + (u2 >> 1) - udiv64(u3, 64'd6) + udiv64(u4, 64'd24);
    for (int k = 0; k < 8; k++) begin
      e = (e * e) >> 30;
    end
    return e;
  endfunction

  // Sigmoid sampled at the middle of each bin over [-8, 8), Q0.16.
  function automatic sig_table_t build_table();
    sig_table_t      t;
    longint unsigned off;
    longint unsigned eight;
    longint unsigned a;
    longint unsigned e;
    longint unsigned den;
    longint unsigned s;
    logic            neg;
    eight = 64'd8 << 30;
    for (int k = 0; k < SIG_DEPTH; k++) begin
      off = ((64'(2 * k + 1)) << 33) >> SIG_AW;
      neg = off < eight;
      a   = neg ? eight - off : off - eight;
      e   = exp_neg_q30(a);
      den = (64'd1 << 30) + e;
      if (neg) begin
        s = udiv64((e << 16) + (den >> 1), den);
      end else begin
        s = udiv64((64'd1 << 46) + (den >> 1), den);
      end
      if (s > 64'd65535) begin
        s = 64'd65535;
      end
      t[k] = s[15:0];
    end
    return t;
  endfunction

  localparam sig_table_t SIG_TABLE = build_table();

endpackage

// ===== rtl/mlpsig_cell.sv =====
// ----------------------------------------------------------------------------
// mlpsig_cell
// One hidden neuron: its weight row, bias and output weight, a MAC over the
// features, the sigmoid, and a product register that shifts toward cell zero.
// ----------------------------------------------------------------------------
module mlpsig_cell (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  mlpsig_pkg::cell_ctrl_t       ctrl_i,
  input  logic                         sel_i,
  input  logic signed [mlpsig_pkg::PROD_W-1:0] prod_i,
  output logic signed [mlpsig_pkg::PROD_W-1:0] prod_o
);
  import mlpsig_pkg::*;

  logic signed [15:0]       w1_q [MAX_INPUTS];
  logic signed [15:0]       b1_q;
  logic signed [15:0]       w2_q;
  logic signed [HACC_W-1:0] acc_q, acc_d;
  logic signed [PROD_W-1:0] prod_q, prod_d;
  logic signed [31:0]       mac_prod;
  logic [SIG_AW-1:0]        sig_idx;
  logic [15:0]              sig_val;

  localparam logic signed [HACC_W-1:0] HLO = -(HACC_W'(8) <<< 20);
  localparam logic signed [HACC_W-1:0] HHI = (HACC_W'(8) <<< 20) - HACC_W'(1);

  assign mac_prod = w1_q[ctrl_i.w_addr] * ctrl_i.x;

  always_comb begin
    if (acc_q < HLO) begin
      sig_idx = '0;
    end else if (acc_q > HHI) begin
      sig_idx = '1;
    end else begin
      sig_idx = {~acc_q[23], acc_q[22:16]};
    end
    sig_val = SIG_TABLE[sig_idx];
  end

  always_comb begin
    acc_d  = acc_q;
    prod_d = prod_q;
    if (ctrl_i.load) begin
      acc_d = HACC_W'({{(HACC_W-24){b1_q[15]}}, b1_q, 8'd0});
    end else if (ctrl_i.mac) begin
      acc_d = acc_q + HACC_W'(mac_prod);
    end
    if (ctrl_i.act) begin
      prod_d = w2_q * $signed({1'b0, sig_val});
    end else if (ctrl_i.shift) begin
      prod_d = prod_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q  <= '0;
      prod_q <= '0;
    end else begin
      acc_q  <= acc_d;
      prod_q <= prod_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sel_i && ctrl_i.wr_w1) begin
      w1_q[ctrl_i.w_addr] <= ctrl_i.w_data;
    end
    if (sel_i && ctrl_i.wr_b1) begin
      b1_q <= ctrl_i.w_data;
    end
    if (sel_i && ctrl_i.wr_w2) begin
      w2_q <= ctrl_i.w_data;
    end
  end

  assign prod_o = prod_q;

endmodule

// ===== rtl/mlp_two_layer_sigmoid_infer_core.sv =====
// ----------------------------------------------------------------------------
// mlp_two_layer_sigmoid_infer_core
// Two-layer perceptron inference with one sigmoid output.
// ----------------------------------------------------------------------------
// Weight beats and feature beats without last are taken while idle. A feature
// beat with last starts a forward pass over a row of 32 hidden cells that
// all run their MACs together: the hidden MACs over the input_count features,
// the hidden sigmoids and output products, the shift of the products down
// the row into the output accumulator over hidden_count cells, and the step
// that forms the logit and prediction. The input is stalled meanwhile, and
// the last step also waits for an unclaimed result.
module mlp_two_layer_sigmoid_infer_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        in_action_i,
  input  logic [9:0]  in_index_i,
  input  logic signed [15:0] in_value_i,
  input  logic        in_last_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] out_prediction_o,
  output logic signed [31:0] out_output_logit_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [5:0]  cfg_data_i
);
  import mlpsig_pkg::*;

  state_e                   state_q, state_d;
  logic [CNT_W-1:0]         cnt_q, cnt_d;
  logic signed [OACC_W-1:0] oacc_q, oacc_d;
  logic signed [15:0]       fbuf_q [MAX_INPUTS];
  logic signed [15:0]       b2_q;
  logic [4:0]               in_cnt_q;
  logic [5:0]               hid_cnt_q;
  logic                     out_valid_q;
  logic [15:0]              pred_q;
  logic signed [31:0]       logit_q;

  cell_ctrl_t               ctrl;
  logic [MAX_HIDDEN-1:0]    sel;
  logic signed [PROD_W-1:0] chain [MAX_HIDDEN+1];
  logic                     in_acc;
  logic                     fin_go;
  logic [CNT_W-1:0]         ni_last;
  logic [CNT_W-1:0]         nh_last;
  logic [9:0]               w2_off;
  logic signed [OACC_W-1:0] shifted;
  logic signed [31:0]       logit;
  logic [SIG_AW-1:0]        out_idx;

  localparam logic signed [OACC_W-1:0] SAT_HI = OACC_W'(64'sd2147483647);
  localparam logic signed [OACC_W-1:0] SAT_LO = -OACC_W'(64'sd2147483648);

  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_acc      = in_valid_i && (state_q == ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign w2_off      = in_index_i - 10'(W2_BASE);

  // Register values outside the legal range saturate into it.
  always_comb begin
    if (in_cnt_q == 5'd0) begin
      ni_last = '0;
    end else if (in_cnt_q > 5'(MAX_INPUTS)) begin
      ni_last = CNT_W'(MAX_INPUTS - 1);
    end else begin
      ni_last = CNT_W'(in_cnt_q - 5'd1);
    end
    if (hid_cnt_q == 6'd0) begin
      nh_last = '0;
    end else if (hid_cnt_q > 6'(MAX_HIDDEN)) begin
      nh_last = CNT_W'(MAX_HIDDEN - 1);
    end else begin
      nh_last = CNT_W'(hid_cnt_q - 6'd1);
    end
  end

  // Floor divide by 16, saturate, then the output sigmoid lookup.
  always_comb begin
    shifted = oacc_q >>> 4;
    if (shifted > SAT_HI) begin
      logit = 32'sh7fffffff;
    end else if (shifted < SAT_LO) begin
      logit = 32'sh80000000;
    end else begin
      logit = shifted[31:0];
    end
    if (logit < -(32'sd8 <<< 24)) begin
      out_idx = '0;
    end else if (logit > (32'sd8 <<< 24) - 32'sd1) begin
      out_idx = '1;
    end else begin
      out_idx = {~logit[27], logit[26:20]};
    end
  end

  always_comb begin
    state_d       = state_q;
    cnt_d         = cnt_q;
    oacc_d        = oacc_q;
    fin_go        = 1'b0;
    sel           = '0;
    ctrl          = '0;
    ctrl.w_data   = in_value_i;
    ctrl.x        = fbuf_q[cnt_q[FEAT_AW-1:0]];
    ctrl.w_addr   = in_index_i[FEAT_AW-1:0];
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc && !in_action_i) begin
          if (in_index_i < 10'(W1_DEPTH)) begin
            ctrl.wr_w1 = 1'b1;
            sel[in_index_i[FEAT_AW +: CELL_AW]] = 1'b1;
          end else if (in_index_i < 10'(W2_BASE)) begin
            ctrl.wr_b1 = 1'b1;
            sel[in_index_i[CELL_AW-1:0]] = 1'b1;
          end else if (in_index_i < 10'(B2_ADDR)) begin
            ctrl.wr_w2 = 1'b1;
            sel[w2_off[CELL_AW-1:0]] = 1'b1;
          end
        end else if (in_acc && in_last_i) begin
          ctrl.load = 1'b1;
          cnt_d     = '0;
          state_d   = ST_HID;
        end
      end
      ST_HID: begin
        ctrl.mac    = 1'b1;
        ctrl.w_addr = cnt_q[FEAT_AW-1:0];
        cnt_d       = cnt_q + CNT_W'(1);
        if (cnt_q == ni_last) begin
          state_d = ST_ACT;
        end
      end
      ST_ACT: begin
        ctrl.act = 1'b1;
        oacc_d   = OACC_W'({{(OACC_W-32){b2_q[15]}}, b2_q, 16'd0});
        cnt_d    = '0;
        state_d  = ST_OUT;
      end
      ST_OUT: begin
        ctrl.shift = 1'b1;
        oacc_d     = oacc_q + OACC_W'(chain[0]);
        cnt_d      = cnt_q + CNT_W'(1);
        if (cnt_q == nh_last) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!out_valid_q || !out_stall_i) begin
          fin_go  = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  for (genvar g = 0; g < MAX_HIDDEN; g++) begin : g_cell
    mlpsig_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (ctrl),
      .sel_i  (sel[g]),
      .prod_i (chain[g+1]),
      .prod_o (chain[g])
    );
  end
  assign chain[MAX_HIDDEN] = '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      in_cnt_q    <= 5'd16;
      hid_cnt_q   <= 6'd32;
      out_valid_q <= 1'b0;
      for (int i = 0; i < MAX_INPUTS; i++) begin
        fbuf_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (cfg_valid_i) begin
        if (cfg_index_i == REG_INPUT_COUNT) begin
          in_cnt_q <= cfg_data_i[4:0];
        end else if (cfg_index_i == REG_HIDDEN_COUNT) begin
          hid_cnt_q <= cfg_data_i;
        end
      end
      if (fin_go) begin
        out_valid_q <= 1'b1;
        for (int i = 0; i < MAX_INPUTS; i++) begin
          fbuf_q[i] <= '0;
        end
      end else begin
        if (out_valid_q && !out_stall_i) begin
          out_valid_q <= 1'b0;
        end
        if (in_acc && in_action_i && in_index_i < 10'(MAX_INPUTS)) begin
          fbuf_q[in_index_i[FEAT_AW-1:0]] <= in_value_i;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    oacc_q <= oacc_d;
    if (in_acc && !in_action_i && in_index_i == 10'(B2_ADDR)) begin
      b2_q <= in_value_i;
    end
    if (fin_go) begin
      pred_q  <= SIG_TABLE[out_idx];
      logit_q <= logit;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign out_prediction_o   = pred_q;
  assign out_output_logit_o = logit_q;

endmodule
